// ----- hdl/tctc_pkg.sv -----
package tctc_pkg;

  localparam int STAMP_W = 16;
  localparam int TMO_W   = 16;
  localparam int NUM_CH  = 3;

  localparam logic [TMO_W-1:0] TMO_RESET = 16'hFFFF;

  typedef struct packed {
    logic               fired;
    logic [STAMP_W-1:0] stamp;
  } lane_t;

  typedef struct packed {
    logic report;
    logic timed_out;
  } rpt_t;

endpackage

// ----- hdl/three_channel_arrival_time_capture.sv -----
// Three-channel arrival-time capture.
// Input channel: one word per timer tick carrying the rising-edge flags of
// comparators A, B and C (in_edge_a/b/c). A word is taken every clock while
// in_ready is high, so the block sustains one tick per cycle.
// The first edge opens a window and starts the elapsed count at zero; each
// channel's first edge in the window latches the count. When all three have
// fired, or the count reaches cfg timeout_period, one report word leaves on
// the output channel: three stamps, three hit flags and timed_out.
// Latency: the report is valid in the cycle after the tick that closed the
// window. The report sits in an output register; in_ready is high whenever
// that register is empty or is being drained, so a receiver stall holds the
// report and back-pressures the input only while the register is full.
// Reset: window idle, count zero, stamps and hit flags clear, timeout_period
// 65535, no report pending. cfg_we writes timeout_period.
module three_channel_arrival_time_capture #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tctc_pkg::TMO_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_edge_a,
  input  logic                          in_edge_b,
  input  logic                          in_edge_c,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tctc_pkg::STAMP_W-1:0]  out_stamp_a,
  output logic [tctc_pkg::STAMP_W-1:0]  out_stamp_b,
  output logic [tctc_pkg::STAMP_W-1:0]  out_stamp_c,
  output logic                          out_hit_a,
  output logic                          out_hit_b,
  output logic                          out_hit_c,
  output logic                          out_timed_out
);
  import tctc_pkg::*;

  logic [TMO_W-1:0]       tmo_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [COUNT_WIDTH-1:0] cnt_eff;
  logic [COUNT_WIDTH:0]   cnt_next;
  logic                   running_r;
  logic                   open;
  logic                   accept;
  logic [STAMP_W-1:0]     stamp_now;
  logic [NUM_CH-1:0]      edges;
  lane_t                  cur   [NUM_CH];
  lane_t                  nxt   [NUM_CH];
  rpt_t                   rpt;

  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [STAMP_W-1:0]     stamp_r [NUM_CH];
  logic [NUM_CH-1:0]      hit_r;
  logic                   timed_out_r;

  assign edges     = {in_edge_c, in_edge_b, in_edge_a};
  assign in_ready  = ~out_valid_r | out_ready;
  assign accept    = in_valid & in_ready;
  assign cnt_eff   = running_r ? cnt_r : '0;
  assign cnt_next  = {1'b0, cnt_eff} + (COUNT_WIDTH+1)'(1);
  assign open      = running_r | (|edges);
  assign stamp_now = STAMP_W'(cnt_eff);

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    tctc_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .accept   (accept),
      .edge_in  (edges[g]),
      .stamp_in (stamp_now),
      .clear    (rpt.report),
      .cur      (cur[g]),
      .nxt      (nxt[g])
    );
  end

  tctc_merge #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_merge (
    .lanes          (nxt),
    .open           (open),
    .cnt_next       (cnt_next),
    .timeout_period (tmo_r),
    .rpt            (rpt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r <= TMO_RESET;
    end else if (cfg_we) begin
      tmo_r <= cfg_wdata;
    end
  end

  // advance the window counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      cnt_r     <= '0;
    end else if (accept) begin
      if (rpt.report) begin
        running_r <= 1'b0;
        cnt_r     <= '0;
      end else if (open) begin
        running_r <= 1'b1;
        cnt_r     <= cnt_next[COUNT_WIDTH-1:0];
      end
    end
  end

  assign out_valid_nxt = (accept & rpt.report) | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the report until taken
  always_ff @(posedge clk) begin
    if (accept & rpt.report) begin
      for (int i = 0; i < NUM_CH; i++) begin
        stamp_r[i] <= nxt[i].stamp;
        hit_r[i]   <= nxt[i].fired;
      end
      timed_out_r <= rpt.timed_out;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_stamp_a   = stamp_r[0];
  assign out_stamp_b   = stamp_r[1];
  assign out_stamp_c   = stamp_r[2];
  assign out_hit_a     = hit_r[0];
  assign out_hit_b     = hit_r[1];
  assign out_hit_c     = hit_r[2];
  assign out_timed_out = timed_out_r;

  a_full_report_all_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r & ~timed_out_r |-> (&hit_r))
    else $error("report without timeout lacks a hit");

  a_idle_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ~running_r |-> (cnt_r == '0) && ~cur[0].fired && ~cur[1].fired && ~cur[2].fired)
    else $error("idle window holds state");

  a_report_closes: assert property (@(posedge clk) disable iff (!rst_n)
    accept & rpt.report |=> ~running_r && out_valid_r)
    else $error("report did not close window");

  a_unhit_stamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r & ~hit_r[0] |-> stamp_r[0] == '0)
    else $error("stamp set for channel that did not fire");

endmodule

// ----- hdl/tctc_lane.sv -----
module tctc_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          edge_in,
  input  logic [tctc_pkg::STAMP_W-1:0]  stamp_in,
  input  logic                          clear,
  output tctc_pkg::lane_t               cur,
  output tctc_pkg::lane_t               nxt
);
  import tctc_pkg::*;

  logic               fired_r;
  logic [STAMP_W-1:0] stamp_r;
  logic               capture;

  assign capture   = edge_in & ~fired_r;
  assign cur.fired = fired_r;
  assign cur.stamp = stamp_r;
  assign nxt.fired = fired_r | capture;
  assign nxt.stamp = capture ? stamp_in : stamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fired_r <= 1'b0;
      stamp_r <= '0;
    end else if (accept) begin
      if (clear) begin
        fired_r <= 1'b0;
        stamp_r <= '0;
      end else begin
        fired_r <= nxt.fired;
        stamp_r <= nxt.stamp;
      end
    end
  end

endmodule

// ----- hdl/tctc_merge.sv -----
module tctc_merge #(
  parameter int COUNT_WIDTH = 16
) (
  input  tctc_pkg::lane_t               lanes [tctc_pkg::NUM_CH],
  input  logic                          open,
  input  logic [COUNT_WIDTH:0]          cnt_next,
  input  logic [tctc_pkg::TMO_W-1:0]    timeout_period,
  output tctc_pkg::rpt_t                rpt
);
  import tctc_pkg::*;

  localparam int CmpW = (COUNT_WIDTH + 1 > TMO_W) ? COUNT_WIDTH + 1 : TMO_W;

  logic all_fired;
  logic expired;

  always_comb begin
    all_fired = 1'b1;
    for (int i = 0; i < NUM_CH; i++) begin
      all_fired = all_fired & lanes[i].fired;
    end
  end

  assign expired = (CmpW'(cnt_next) >= CmpW'(timeout_period)) | cnt_next[COUNT_WIDTH];

  assign rpt.report    = all_fired | (open & expired);
  assign rpt.timed_out = ~all_fired;

endmodule

// ----- verif/tb_three_channel_arrival_time_capture.sv -----
module tb_three_channel_arrival_time_capture;
  import tctc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned COUNT_MAX = 65535;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp_a;
    logic [STAMP_W-1:0] stamp_b;
    logic [STAMP_W-1:0] stamp_c;
    logic               hit_a;
    logic               hit_b;
    logic               hit_c;
    logic               timed_out;
  } report_t;

  class arrival_book;
    logic [TMO_W-1:0]   period = TMO_RESET;
    int unsigned        elapsed = 0;
    bit                 running = 0;
    logic [STAMP_W-1:0] stamp [NUM_CH];
    bit                 fired [NUM_CH];
    report_t            awaited [$];
    int                 errors = 0;

    function void close_window(bit why_timeout);
      report_t r;
      r.stamp_a = fired[0] ? stamp[0] : '0;
      r.stamp_b = fired[1] ? stamp[1] : '0;
      r.stamp_c = fired[2] ? stamp[2] : '0;
      r.hit_a = fired[0];
      r.hit_b = fired[1];
      r.hit_c = fired[2];
      r.timed_out = why_timeout;
      awaited.push_back(r);
      elapsed = 0;
      running = 0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        stamp[ch] = '0;
        fired[ch] = 0;
      end
    endfunction

    function void note_tick(logic [NUM_CH-1:0] edges);
      int unsigned nxt;
      if (!running && edges != '0) begin
        running = 1;
        elapsed = 0;
      end
      if (running) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          if (edges[ch] && !fired[ch]) begin
            stamp[ch] = elapsed[STAMP_W-1:0];
            fired[ch] = 1;
          end
        end
      end
      if (fired[0] && fired[1] && fired[2]) begin
        close_window(1'b0);
      end else if (running) begin
        nxt = elapsed + 1;
        if (nxt >= int'(period) || nxt > COUNT_MAX) begin
          close_window(1'b1);
        end else begin
          elapsed = nxt;
        end
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (awaited.size() == 0) begin
        $display("%0t unexpected report: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("stamp_a", want.stamp_a, got.stamp_a);
      compare_field("stamp_b", want.stamp_b, got.stamp_b);
      compare_field("stamp_c", want.stamp_c, got.stamp_c);
      compare_field("hit_a", want.hit_a, got.hit_a);
      compare_field("hit_b", want.hit_b, got.hit_b);
      compare_field("hit_c", want.hit_c, got.hit_c);
      compare_field("timed_out", want.timed_out, got.timed_out);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [TMO_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_edge_a = 1'b0;
  logic               in_edge_b = 1'b0;
  logic               in_edge_c = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [STAMP_W-1:0] out_stamp_a;
  logic [STAMP_W-1:0] out_stamp_b;
  logic [STAMP_W-1:0] out_stamp_c;
  logic               out_hit_a;
  logic               out_hit_b;
  logic               out_hit_c;
  logic               out_timed_out;

  arrival_book book;
  bit          quiet = 0;
  int unsigned cycles = 0;

  three_channel_arrival_time_capture DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_edge_a    (in_edge_a),
    .in_edge_b    (in_edge_b),
    .in_edge_c    (in_edge_c),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_stamp_a  (out_stamp_a),
    .out_stamp_b  (out_stamp_b),
    .out_stamp_c  (out_stamp_c),
    .out_hit_a    (out_hit_a),
    .out_hit_b    (out_hit_b),
    .out_hit_c    (out_hit_c),
    .out_timed_out(out_timed_out)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      book.note_tick({in_edge_c, in_edge_b, in_edge_a});
    end
  end

  always @(posedge clk) begin
    report_t got;
    if (rst_n && out_valid && out_ready) begin
      got.stamp_a = out_stamp_a;
      got.stamp_b = out_stamp_b;
      got.stamp_c = out_stamp_c;
      got.hit_a = out_hit_a;
      got.hit_b = out_hit_b;
      got.hit_c = out_hit_c;
      got.timed_out = out_timed_out;
      book.check_report(got);
    end
  end

  function automatic logic coin(int pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic send_tick(input logic [2:0] edges);
    while (!quiet && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_edge_a <= edges[0];
    in_edge_b <= edges[1];
    in_edge_c <= edges[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold off until every report is back and the block has settled
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_period(input logic [TMO_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.period = value;
  endtask

  task automatic run_phase(input logic [TMO_W-1:0] value, input int words, input int pct);
    wait_drained();
    write_period(value);
    repeat (words) send_tick({coin(pct), coin(pct), coin(pct)});
  endtask

  initial begin
    book = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_period(16'd5);
    send_tick(3'b000);
    send_tick(3'b111);
    send_tick(3'b001);
    send_tick(3'b010);
    send_tick(3'b001);
    send_tick(3'b100);
    send_tick(3'b110);
    repeat (4) send_tick(3'b000);

    wait_drained();
    write_period(16'd0);
    send_tick(3'b100);
    send_tick(3'b011);
    send_tick(3'b000);

    wait_drained();
    write_period(16'd1);
    send_tick(3'b101);

    // lower the period while a window is open
    wait_drained();
    write_period(16'd100);
    send_tick(3'b001);
    repeat (9) send_tick(3'b000);
    wait_drained();
    write_period(16'd3);
    send_tick(3'b010);

    run_phase(16'd7, 100, 20);
    run_phase(16'd1, 60, 30);
    quiet = 1;
    run_phase(16'd65535, 120, 10);
    quiet = 0;
    run_phase(16'd2, 80, 50);
    run_phase(16'd30, 100, 5);
    run_phase(16'd64, 100, 15);
    repeat (3) run_phase(16'($urandom_range(1, 40)), 80, $urandom_range(5, 60));

    wait_drained();
    if (book.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
